// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/dsfe_pkg.sv -----
// Package: constants, register codes and shared types of the frame encoder.
package dsfe_pkg;

    localparam int CHANNELS    = 4;
    localparam int FRAME_SLOTS = 18;
    localparam int NUM_IN_CH   = 4;
    localparam int DATA_BITS   = 16;

    localparam int THR_W      = 11;
    localparam int PULSE_W    = 9;
    localparam int SLOT_NUM_W = 5;
    localparam int SLOT_W     = $clog2(FRAME_SLOTS);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int NIB_W      = 4;

    localparam logic [PULSE_W-1:0] ZERO_W_RESET = 9'd105;
    localparam logic [PULSE_W-1:0] ONE_W_RESET  = 9'd210;
    localparam logic [THR_W-1:0]   OFFSET_RESET = 11'd48;
    localparam logic [THR_W-1:0]   MAX_CMD      = 11'h7FF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZERO_W = 2'd0,
        REG_ONE_W  = 2'd1,
        REG_OFFSET = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [PULSE_W-1:0] zero_w;
        logic [PULSE_W-1:0] one_w;
        logic [THR_W-1:0]   offset;
    } t_cfg;

    typedef struct packed {
        logic load;       // capture a new frame
        logic shift;      // move to the next bit
        logic data_slot;  // current slot carries a data bit
    } t_lane_ctl;

endpackage

// ----- hw/rtl/dsfe_if.sv -----
// Valid/ready channel interfaces: request, slot word and configuration write.
interface dsfe_in_if;
    import dsfe_pkg::*;
    logic             valid;
    logic             ready;
    logic [THR_W-1:0] throttle_a;
    logic [THR_W-1:0] throttle_b;
    logic [THR_W-1:0] throttle_c;
    logic [THR_W-1:0] throttle_d;
    logic             armed;
    modport source (output valid, throttle_a, throttle_b, throttle_c, throttle_d, armed,
                    input ready);
    modport sink (input valid, throttle_a, throttle_b, throttle_c, throttle_d, armed,
                  output ready);
endinterface

interface dsfe_out_if;
    import dsfe_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [PULSE_W-1:0]    pulse_a;
    logic [PULSE_W-1:0]    pulse_b;
    logic [PULSE_W-1:0]    pulse_c;
    logic [PULSE_W-1:0]    pulse_d;
    logic [SLOT_NUM_W-1:0] slot_number;
    logic                  last_slot;
    modport source (output valid, pulse_a, pulse_b, pulse_c, pulse_d, slot_number, last_slot,
                    input ready);
    modport sink (input valid, pulse_a, pulse_b, pulse_c, pulse_d, slot_number, last_slot,
                  output ready);
endinterface

interface dsfe_cfg_if;
    import dsfe_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/dsfe_lane.sv -----
// One channel lane: command value, checksum and the frame bit shifter.
module dsfe_lane (
    input  logic                          i_clk,
    input  logic [dsfe_pkg::THR_W-1:0]    i_throttle,
    input  logic                          i_armed,
    input  dsfe_pkg::t_cfg                i_cfg,
    input  dsfe_pkg::t_lane_ctl           i_ctl,
    output logic [dsfe_pkg::PULSE_W-1:0]  o_pulse
);
    import dsfe_pkg::*;

    logic [THR_W:0]         sum;
    logic [THR_W-1:0]       cmd;
    logic [THR_W:0]         cmd_sh;
    logic [NIB_W-1:0]       crc;
    logic [DATA_BITS-1:0]   n_frame;
    logic [DATA_BITS-1:0]   r_frame;

    always_comb begin
        sum = {1'b0, i_throttle} + {1'b0, i_cfg.offset};
        if (!i_armed) begin
            cmd = '0;
        end else if (sum[THR_W]) begin
            cmd = MAX_CMD;
        end else begin
            cmd = sum[THR_W-1:0];
        end
        cmd_sh  = {cmd, 1'b0};  // telemetry bit stays zero
        crc     = cmd_sh[3:0] ^ cmd_sh[7:4] ^ cmd_sh[11:8];
        n_frame = {cmd_sh, crc};
    end

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_frame <= n_frame;
        end else if (i_ctl.shift) begin
            r_frame <= {r_frame[DATA_BITS-2:0], 1'b0};
        end
    end

    always_comb begin
        if (!i_ctl.data_slot) begin
            o_pulse = '0;
        end else if (r_frame[DATA_BITS-1]) begin
            o_pulse = i_cfg.one_w;
        end else begin
            o_pulse = i_cfg.zero_w;
        end
    end

endmodule

// ----- hw/rtl/dsfe_merge.sv -----
// Merge stage: combines the lane pulses into one registered slot word.
module dsfe_merge (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  logic [dsfe_pkg::PULSE_W-1:0]    i_pulse [dsfe_pkg::NUM_IN_CH],
    input  logic [dsfe_pkg::SLOT_NUM_W-1:0] i_slot_number,
    input  logic                            i_last_slot,
    output logic                            o_can_load,
    dsfe_out_if.source                      o_slot
);
    import dsfe_pkg::*;

    logic                  r_valid;
    logic [PULSE_W-1:0]    r_pulse [NUM_IN_CH];
    logic [SLOT_NUM_W-1:0] r_slot_number;
    logic                  r_last_slot;

    assign o_can_load = !r_valid || o_slot.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_pulse       <= i_pulse;
            r_slot_number <= i_slot_number;
            r_last_slot   <= i_last_slot;
        end
    end

    assign o_slot.valid       = r_valid;
    assign o_slot.pulse_a     = r_pulse[0];
    assign o_slot.pulse_b     = r_pulse[1];
    assign o_slot.pulse_c     = r_pulse[2];
    assign o_slot.pulse_d     = r_pulse[3];
    assign o_slot.slot_number = r_slot_number;
    assign o_slot.last_slot   = r_last_slot;

endmodule

// ----- hw/rtl/dsfe_top.sv -----
// Top level: four-channel DShot600 frame encoder with slot sequencer.
//
// Usage:
//   i_req   request word: four 11-bit throttles plus the armed flag.
//   o_slot  slot word: four pulse high-times, slot number, last-slot flag.
//   i_cfg   register write: index 0 zero-bit width, 1 one-bit width,
//           2 throttle offset; index 3 is ignored. Always ready.
// Each request yields 18 slot words, frame MSB first: 16 data slots then
// two padding slots with zero pulses, the final one flagged last_slot.
// The request is registered in the lanes and the slot counter, and the first
// slot word then moves from there into the output register.
// Throughput: one slot word per cycle while the receiver does not stall, so
// one request per frame; the slot counter walks the frame one bit a cycle.
// A new request is taken in the same cycle the final slot of the previous
// frame moves into the output register, so frames run back to back.
// If the receiver stalls, the output register holds its word and the lanes
// and slot counter freeze; nothing is dropped.
// Reset (synchronous, active low) clears the sequencer and the output valid
// and restores the register defaults 105, 210 and 48.
module dshot_four_channel_frame_encoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dsfe_in_if.sink     i_req,
    dsfe_out_if.source  o_slot,
    dsfe_cfg_if.sink    i_cfg
);
    import dsfe_pkg::*;
    `include "assert_macros.svh"

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FRAME_SLOTS - 1);
    localparam logic [SLOT_W-1:0] DATA_END  = SLOT_W'(DATA_BITS);

    // configuration registers
    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_w <= ZERO_W_RESET;
            r_cfg.one_w  <= ONE_W_RESET;
            r_cfg.offset <= OFFSET_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ZERO_W: r_cfg.zero_w <= i_cfg.data[PULSE_W-1:0];
                REG_ONE_W:  r_cfg.one_w  <= i_cfg.data[PULSE_W-1:0];
                REG_OFFSET: r_cfg.offset <= i_cfg.data[THR_W-1:0];
                default:    ;
            endcase
        end
    end

    // slot sequencer
    logic              r_busy;
    logic [SLOT_W-1:0] r_slot;
    logic              can_load;
    logic              advance;
    logic              at_last;
    logic              accept;
    t_lane_ctl         lane_ctl;

    assign at_last     = (r_slot == LAST_SLOT);
    assign advance     = r_busy && can_load;
    // next frame may load while the final slot leaves
    assign i_req.ready = !r_busy || (advance && at_last);
    assign accept      = i_req.valid && i_req.ready;

    assign lane_ctl.load      = accept;
    assign lane_ctl.shift     = advance;
    assign lane_ctl.data_slot = (r_slot < DATA_END);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_slot <= '0;
        end else if (accept) begin
            r_busy <= 1'b1;
            r_slot <= '0;
        end else if (advance) begin
            if (at_last) begin
                r_busy <= 1'b0;
                r_slot <= '0;
            end else begin
                r_slot <= r_slot + 1'b1;
            end
        end
    end

    // lanes
    logic [THR_W-1:0]   thr   [NUM_IN_CH];
    logic [PULSE_W-1:0] pulse [NUM_IN_CH];

    assign thr[0] = i_req.throttle_a;
    assign thr[1] = i_req.throttle_b;
    assign thr[2] = i_req.throttle_c;
    assign thr[3] = i_req.throttle_d;

    for (genvar ch = 0; ch < NUM_IN_CH; ch++) begin : g_lane
        if (ch < CHANNELS) begin : g_used
            dsfe_lane u_lane (
                .i_clk      (i_clk),
                .i_throttle (thr[ch]),
                .i_armed    (i_req.armed),
                .i_cfg      (r_cfg),
                .i_ctl      (lane_ctl),
                .o_pulse    (pulse[ch])
            );
        end else begin : g_unused
            assign pulse[ch] = '0;
        end
    end

    // merge and output register
    dsfe_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (advance),
        .i_pulse       (pulse),
        .i_slot_number (SLOT_NUM_W'(r_slot)),
        .i_last_slot   (at_last),
        .o_can_load    (can_load),
        .o_slot        (o_slot)
    );

    // checks
    `ASSERT_NOW(a_last_is_final, i_clk, i_rst_n,
        o_slot.valid && o_slot.last_slot,
        o_slot.slot_number == SLOT_NUM_W'(FRAME_SLOTS - 1))
    `ASSERT_NOW(a_pad_zero, i_clk, i_rst_n,
        o_slot.valid && (o_slot.slot_number >= SLOT_NUM_W'(DATA_BITS)),
        o_slot.pulse_a == '0 && o_slot.pulse_b == '0 &&
        o_slot.pulse_c == '0 && o_slot.pulse_d == '0)
    `ASSERT_NEXT(a_slot_step, i_clk, i_rst_n,
        advance && !at_last && !accept,
        r_busy && r_slot == $past(r_slot) + 1'b1)
    `ASSERT_NEXT(a_frame_start, i_clk, i_rst_n,
        accept,
        r_busy && r_slot == '0)

endmodule
